[sv/satlru_pkg.sv]
// ============================================================================
// satlru_pkg
// Shared sizes, codes and types of the set-associative tag array with
// matrix LRU replacement.
// ============================================================================
package satlru_pkg;

    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 4;
    localparam int INDEX_BITS  = 5;
    localparam int TAG_BITS    = 16;

    localparam int SETS     = 1 << INDEX_BITS;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [INDEX_BITS-1:0]           set_idx_t;
    typedef logic [TAG_BITS-1:0]             tag_t;
    typedef logic [WAY_BITS-1:0]             way_idx_t;
    typedef logic [WAYS-1:0]                 way_vec_t;
    typedef logic [WAYS-1:0][TAG_BITS-1:0]   tag_row_t;

    // operation codes
    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_READ  = 2'd0;
    localparam op_code_t OP_WRITE = 2'd1;
    localparam op_code_t OP_FILL  = 2'd2;

    // result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_HIT       = 3'd0;
    localparam status_t ST_MISS      = 3'd1;
    localparam status_t ST_FILL_INV  = 3'd2;
    localparam status_t ST_FILL_REPL = 3'd3;
    localparam status_t ST_FILL_FAIL = 3'd4;

    // tag store write request
    typedef struct packed {
        logic     en;
        set_idx_t idx;
        way_idx_t way;
        tag_t     tag;
    } tag_wr_t;

    // LRU matrix update: make one way most recent
    typedef struct packed {
        logic     en;
        set_idx_t idx;
        way_idx_t way;
    } lru_upd_t;

    // lowest set bit of a way vector, zero when none is set
    function automatic way_idx_t first_way(way_vec_t v);
        way_idx_t w;
        w = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                w = way_idx_t'(i);
            end
        end
        return w;
    endfunction

endpackage

[sv/satlru_tag_ram.sv]
// ============================================================================
// satlru_tag_ram
// Tag store: one row of WAYS tags per set, one way written per cycle,
// whole row read with registered data.
// ============================================================================
module satlru_tag_ram (
    input  logic                 clk,
    input  logic                 rd_en,
    input  satlru_pkg::set_idx_t rd_idx,
    output satlru_pkg::tag_row_t rd_row,
    input  satlru_pkg::tag_wr_t  wr
);
    import satlru_pkg::*;

    tag_row_t mem [SETS];
    tag_row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx][wr.way] <= wr.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_idx];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

[sv/satlru_lru.sv]
// ============================================================================
// satlru_lru
// Matrix LRU state: one WAYS x WAYS bit matrix per set. Reports which rows
// of the looked-up set are all zero and applies most-recent updates.
// ============================================================================
module satlru_lru (
    input  logic                 clk,
    input  logic                 rst_n,
    input  satlru_pkg::set_idx_t rd_idx,
    output satlru_pkg::way_vec_t zero_rows,
    input  satlru_pkg::lru_upd_t upd
);
    import satlru_pkg::*;

    way_vec_t rows_reg [SETS][WAYS];
    way_vec_t rows_next [WAYS];
    way_vec_t sel_mask;

    // make way most recent: clear its column, fill its row except the diagonal
    always_comb
    begin
        sel_mask = way_vec_t'(1) << upd.way;
        for (int j = 0; j < WAYS; j++)
        begin
            rows_next[j] = rows_reg[upd.idx][j] & ~sel_mask;
        end
        rows_next[upd.way] = ~sel_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                for (int j = 0; j < WAYS; j++)
                begin
                    rows_reg[s][j] <= '0;
                end
            end
        end
        else if (upd.en)
        begin
            rows_reg[upd.idx] <= rows_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < WAYS; j++)
        begin
            zero_rows[j] = (rows_reg[rd_idx][j] == '0);
        end
    end

endmodule

[sv/set_assoc_tag_array_matrix_lru_top.sv]
// ============================================================================
// set_assoc_tag_array_matrix_lru_top
// Tag and valid array of a set-associative cache with matrix LRU replacement.
// ============================================================================
// Usage:
//   Command channel: drive operation and address with start high; the item is
//   taken at that clock edge (busy stays low, so one item can enter per cycle).
//   Operations: read lookup, write lookup, fill after miss.
//   Result channel: status and way appear for exactly one cycle with done
//   high, once the item has passed the input register and the result
//   register. The receiver cannot stall, so results are never held back or
//   queued. Path: input register plus tag RAM read, then result register.
//   Throughput: 1 item per cycle, set by the single lookup/update stage; each
//   item's valid, LRU and tag updates land at the same edge as its result, so
//   the next item already sees them. A tag written in the previous cycle is
//   forwarded around the registered tag RAM read.
//   Reset: valid bits and all LRU matrices clear at once; the tag RAM needs no
//   clearing since a tag is only compared while its valid bit is set. The
//   block takes items right after reset.
// ============================================================================
module set_assoc_tag_array_matrix_lru_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             operation,
    input  logic [31:0]            address,
    output logic                   done,
    output logic [2:0]             status,
    output satlru_pkg::way_idx_t   way
);
    import satlru_pkg::*;

    // input register
    logic      vld_reg;
    op_code_t  op_reg;
    set_idx_t  idx_reg;
    tag_t      tag_reg;

    // forward of the last tag write
    tag_wr_t   byp_reg;

    // valid bits
    way_vec_t  valid_reg [SETS];

    // result register
    logic      done_reg;
    status_t   status_reg;
    way_idx_t  way_reg;

    // stage logic
    tag_row_t  rd_row;
    tag_row_t  row_eff;
    way_vec_t  vb;
    way_vec_t  hit_vec;
    way_vec_t  zero_rows;
    status_t   status_next;
    way_idx_t  way_next;
    tag_wr_t   tag_wr;
    lru_upd_t  lru_upd;

    set_idx_t  in_idx;
    tag_t      in_tag;

    // always ready: every item finishes in the single stage
    assign busy = 1'b0;

    assign in_idx = address[OFFSET_BITS +: INDEX_BITS];
    assign in_tag = address[OFFSET_BITS + INDEX_BITS +: TAG_BITS];

    satlru_tag_ram u_tag_ram (
        .clk    (clk),
        .rd_en  (start),
        .rd_idx (in_idx),
        .rd_row (rd_row),
        .wr     (tag_wr)
    );

    satlru_lru u_lru (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (idx_reg),
        .zero_rows (zero_rows),
        .upd       (lru_upd)
    );

    // capture the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= operation;
            idx_reg <= in_idx;
            tag_reg <= in_tag;
        end
    end

    // hold the last write so the next lookup sees it past the RAM read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= '0;
        end
        else
        begin
            byp_reg <= tag_wr;
        end
    end

    // lookup, victim choice and state update requests
    always_comb
    begin
        row_eff = rd_row;
        if (byp_reg.en && (byp_reg.idx == idx_reg))
        begin
            row_eff[byp_reg.way] = byp_reg.tag;
        end

        vb = valid_reg[idx_reg];
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = vb[w] && (row_eff[w] == tag_reg);
        end

        status_next = ST_MISS;
        way_next    = '0;

        case (op_reg) inside
            OP_READ, OP_WRITE:
            begin
                if (|hit_vec)
                begin
                    status_next = ST_HIT;
                    way_next    = first_way(hit_vec);
                end
            end
            OP_FILL:
            begin
                if (|(~vb))
                begin
                    status_next = ST_FILL_INV;
                    way_next    = first_way(~vb);
                end
                else if (|zero_rows)
                begin
                    status_next = ST_FILL_REPL;
                    way_next    = first_way(zero_rows);
                end
                else
                begin
                    status_next = ST_FILL_FAIL;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase

        tag_wr.en  = vld_reg && ((status_next == ST_FILL_INV) ||
                                 (status_next == ST_FILL_REPL));
        tag_wr.idx = idx_reg;
        tag_wr.way = way_next;
        tag_wr.tag = tag_reg;

        lru_upd.en  = tag_wr.en || (vld_reg && (status_next == ST_HIT));
        lru_upd.idx = idx_reg;
        lru_upd.way = way_next;
    end

    // set valid on a fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (tag_wr.en)
        begin
            valid_reg[idx_reg][way_next] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            status_reg <= status_next;
            way_reg    <= way_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign way    = way_reg;

`ifndef SYNTHESIS
    // every accepted item yields its result with done high
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("result missing two cycles after accept");

    // once all ways are valid the matrix always has exactly one LRU row
    a_no_fill_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != ST_FILL_FAIL))
        else $error("fill found no victim way");

    // a miss reports way zero
    a_miss_way_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_MISS)) |-> (way == '0))
        else $error("miss with nonzero way");

    // LRU update only for hits and fills of a live item
    a_lru_upd_live: assert property (@(posedge clk) disable iff (!rst_n)
        lru_upd.en |-> vld_reg)
        else $error("LRU update without an item in the stage");
`endif

endmodule

[tb/set_assoc_tag_array_matrix_lru_top_tb.sv]
// ============================================================================
// set_assoc_tag_array_matrix_lru_top_tb
// Self-checking bench for the 4-way tag array with matrix LRU replacement.
// Drives read lookups, write lookups, fills and the unused operation code
// through the start/busy command port. A shadow copy of the tag, valid and
// recency state predicts status and way for every accepted item. Each done
// strobe is checked against the oldest pending prediction.
// ============================================================================
module set_assoc_tag_array_matrix_lru_top_tb;

    import satlru_pkg::*;

    // operation code that the block treats as a no-op miss
    localparam op_code_t OP_UNUSED = 2'd3;

    // sender pacing styles
    localparam int PACE_NONE   = 0;
    localparam int PACE_BURSTY = 1;
    localparam int PACE_SPARSE = 2;

    // candidate tags per set for random traffic; more than WAYS forces eviction
    localparam int POOL_DEPTH = 6;

    // cycles without any accepted item or result before the run is abandoned
    localparam int STALL_LIMIT = 500;

    typedef struct packed {
        status_t  status;
        way_idx_t way;
    } cache_reply_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    op_code_t   operation;
    logic [31:0] address;
    logic       done;
    status_t    status;
    way_idx_t   way;

    // shadow copy of the block's state
    tag_t       line_tag     [SETS][WAYS];
    bit         line_valid   [SETS][WAYS];
    way_vec_t   recency_rows [SETS][WAYS];

    // replies predicted for accepted items, oldest first
    cache_reply_t reply_q[$];

    tag_t       tag_pool [SETS][POOL_DEPTH];
    int         items_sent;
    int         fail_count;
    int         stall_cycles;

    set_assoc_tag_array_matrix_lru_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .address   (address),
        .done      (done),
        .status    (status),
        .way       (way)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow cache
    // ------------------------------------------------------------------------

    // Clear valid bits and recency rows; tags read as zero until written.
    task automatic reset_shadow();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                line_tag[s][w]     = '0;
                line_valid[s][w]   = 1'b0;
                recency_rows[s][w] = '0;
            end
        end
    endtask

    // Make a way most recent: clear its column everywhere, set its own row
    // to all ones except the diagonal.
    function automatic void promote_way(input set_idx_t s, input int w);
        for (int j = 0; j < WAYS; j++)
        begin
            recency_rows[s][j][w] = 1'b0;
        end
        recency_rows[s][w] = ~(way_vec_t'(1) << w);
    endfunction

    // Apply one access to the shadow state and return the reply it produces.
    function automatic void shadow_cache_access(input op_code_t op,
                                                input logic [31:0] addr,
                                                output status_t st,
                                                output way_idx_t wy);
        set_idx_t s;
        tag_t     t;
        int       pick;
        s    = addr[OFFSET_BITS +: INDEX_BITS];
        t    = addr[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
        st   = ST_MISS;
        wy   = '0;
        pick = -1;
        if (op == OP_READ || op == OP_WRITE)
        begin
            // both lookups need the valid bit to hit
            for (int w = 0; w < WAYS; w++)
            begin
                if (pick < 0 && line_valid[s][w] && line_tag[s][w] == t)
                begin
                    pick = w;
                end
            end
            if (pick >= 0)
            begin
                st = ST_HIT;
            end
        end
        else if (op == OP_FILL)
        begin
            // lowest invalid way first, then the way with an all-zero row
            for (int w = 0; w < WAYS; w++)
            begin
                if (pick < 0 && !line_valid[s][w])
                begin
                    pick = w;
                end
            end
            if (pick >= 0)
            begin
                st = ST_FILL_INV;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (pick < 0 && recency_rows[s][w] == '0)
                    begin
                        pick = w;
                    end
                end
                st = (pick >= 0) ? ST_FILL_REPL : ST_FILL_FAIL;
            end
            if (pick >= 0)
            begin
                line_tag[s][pick]   = t;
                line_valid[s][pick] = 1'b1;
            end
        end
        if (pick >= 0)
        begin
            promote_way(s, pick);
            wy = way_idx_t'(pick);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Build an address from tag and set; offset and upper bits stay random.
    function automatic logic [31:0] pack_addr(input tag_t t, input set_idx_t s);
        logic [31:0] a;
        a = $urandom;
        a[OFFSET_BITS +: INDEX_BITS]             = s;
        a[OFFSET_BITS + INDEX_BITS +: TAG_BITS]  = t;
        return a;
    endfunction

    // Present one item at the falling edge and hold it until busy is low at
    // a rising edge; start stays high so a following item can go back to back.
    task automatic send_access(input op_code_t op, input logic [31:0] addr,
                               output status_t st);
        cache_reply_t r;
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        address   <= addr;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        shadow_cache_access(op, addr, r.status, r.way);
        reply_q.push_back(r);
        items_sent++;
        st = r.status;
    endtask

    // Drop start and hold it low for a gap of length n.
    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Pick a gap after an item: mostly none or short, now and then long.
    task automatic pace(input int mode);
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        n    = 0;
        if (mode == PACE_BURSTY)
        begin
            if (roll >= 97)
                n = $urandom_range(8, 40);
            else if (roll >= 75)
                n = $urandom_range(1, 3);
        end
        else if (mode == PACE_SPARSE)
        begin
            if (roll >= 90)
                n = $urandom_range(8, 40);
            else if (roll >= 30)
                n = $urandom_range(1, 4);
        end
        hold_off(n);
    endtask

    // Stop sending and wait until every predicted reply has come back.
    task automatic wait_drain();
        @(negedge clk);
        start <= 1'b0;
        while (reply_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: each done strobe pops the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_replies
        cache_reply_t want;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("done with no item outstanding: status %0d way %0d",
                           status, way);
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (way !== want.way)
                    begin
                        $error("way: expected %0d, actual %0d", want.way, way);
                        fail_count++;
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                $error("done: expected 0 or 1, actual %b", done);
                fail_count++;
            end
        end
    end

    // Abandon the run when neither side has moved for too long.
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("set_assoc_tag_array_matrix_lru_top_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lookups on an empty cache miss; the unused code misses too.
    task automatic test_cold_lookups();
        status_t st;
        send_access(OP_READ, 32'h0000_0000, st);
        send_access(OP_WRITE, 32'hFFFF_FFFF, st);
        send_access(OP_UNUSED, $urandom, st);
    endtask

    // Fill invalid ways, then hit on them with both lookups and at the
    // extreme offsets and addresses.
    task automatic test_fill_and_hit();
        status_t st;
        tag_t    fill_tags[WAYS];
        fill_tags = '{16'hFFFF, 16'h0001, 16'h8000, 16'h1234};
        send_access(OP_FILL, 32'h0000_0000, st);
        send_access(OP_READ, 32'h0000_000F, st);
        send_access(OP_WRITE, 32'h0000_0008, st);
        hold_off(2);
        for (int i = 0; i < WAYS; i++)
        begin
            send_access(OP_FILL, pack_addr(fill_tags[i], set_idx_t'(SETS - 1)), st);
        end
        // all-ones address lands in the last set with tag FFFF
        send_access(OP_READ, 32'hFFFF_FFFF, st);
    endtask

    // Steer recency in the full last set, then evict and refill.
    task automatic test_lru_replacement();
        status_t  st;
        set_idx_t s;
        s = set_idx_t'(SETS - 1);
        send_access(OP_READ, pack_addr(16'h0001, s), st);
        send_access(OP_WRITE, pack_addr(16'hFFFF, s), st);
        send_access(OP_FILL, pack_addr(16'h5555, s), st);
        send_access(OP_READ, pack_addr(16'h8000, s), st);
        // a tag already present gets a second copy in the LRU way
        send_access(OP_FILL, pack_addr(16'h0001, s), st);
        send_access(OP_READ, pack_addr(16'h0001, s), st);
    endtask

    // Write lookups need the valid bit; the unused code leaves recency alone.
    task automatic test_lookup_corner_cases();
        status_t  st;
        set_idx_t s;
        s = set_idx_t'(SETS - 1);
        send_access(OP_WRITE, pack_addr(16'h0000, set_idx_t'(5)), st);
        send_access(OP_READ, pack_addr(16'h0000, set_idx_t'(5)), st);
        send_access(OP_UNUSED, pack_addr(16'h0001, s), st);
        send_access(OP_FILL, pack_addr(16'hAAAA, s), st);
        send_access(OP_UNUSED, 32'hFFFF_FFFF, st);
    endtask

    // Send a burst, drain completely, then send again.
    task automatic test_drain_pause();
        status_t st;
        for (int i = 0; i < 20; i++)
        begin
            send_access(op_code_t'($urandom_range(0, 2)), pack_addr(
                tag_pool[i % SETS][i % POOL_DEPTH], set_idx_t'(i % SETS)), st);
        end
        wait_drain();
        for (int i = 0; i < 20; i++)
        begin
            send_access(OP_READ, pack_addr(
                tag_pool[i % SETS][i % POOL_DEPTH], set_idx_t'(i % SETS)), st);
        end
    endtask

    // Mostly lookup-then-fill-on-miss sequences over a small tag pool per
    // set, with some fully random items mixed in.
    task automatic test_random_traffic(input int item_goal, input int mode);
        int          stop_at;
        int          roll;
        set_idx_t    s;
        tag_t        t;
        logic [31:0] a;
        op_code_t    op;
        status_t     st;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            s    = set_idx_t'($urandom_range(0, SETS - 1));
            if (roll < 80)
            begin
                t  = tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)];
                a  = pack_addr(t, s);
                op = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
                send_access(op, a, st);
                pace(mode);
                if (st == ST_MISS && $urandom_range(0, 9) != 0)
                begin
                    send_access(OP_FILL, a, st);
                    pace(mode);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        send_access(OP_READ, pack_addr(t, s), st);
                        pace(mode);
                    end
                end
            end
            else
            begin
                op = op_code_t'($urandom_range(0, 3));
                send_access(op, $urandom, st);
                pace(mode);
            end
            if ($urandom_range(0, 199) == 0)
            begin
                wait_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // drive every input to a known value from time zero
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_READ;
        address    = '0;
        items_sent = 0;
        fail_count = 0;
        reset_shadow();
        for (int s = 0; s < SETS; s++)
        begin
            for (int k = 0; k < POOL_DEPTH; k++)
            begin
                tag_pool[s][k] = tag_t'($urandom);
            end
        end

        // hold reset low, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_cold_lookups();
        test_fill_and_hit();
        test_lru_replacement();
        test_lookup_corner_cases();
        test_drain_pause();
        test_random_traffic(600, PACE_NONE);
        test_random_traffic(550, PACE_BURSTY);
        test_random_traffic(550, PACE_SPARSE);

        // drain, then keep watching for any stray strobe before the verdict
        wait_drain();
        repeat (6) @(posedge clk);

        if (fail_count == 0)
            $display("set_assoc_tag_array_matrix_lru_top_tb: clean");
        else
            $display("set_assoc_tag_array_matrix_lru_top_tb: errors");
        $finish;
    end

endmodule
